>>> sv/afbs_pkg.sv
// ----------------------------------------------------------------------------
// afbs_pkg
// Shared types and constants for the function bound scan unit: result kinds,
// item opcodes, register indexes and the AArch64 instruction patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package afbs_pkg;

  localparam int WORD_WIDTH   = 32;
  localparam int STEP_WIDTH   = 19;
  localparam int PCOUNT_WIDTH = 3;

  localparam logic [PCOUNT_WIDTH-1:0] PROLOGUE_LIMIT = 3'd4;
  localparam int MAX_FUNC_SIZE = 1024 * 1024;

  // stp x29, x30, [sp, #imm] (signed offset and pre-index forms)
  localparam logic [WORD_WIDTH-1:0] FRAME_PAIR_MASK  = 32'hFFC0_7FFF;
  localparam logic [WORD_WIDTH-1:0] FRAME_PAIR_OFF   = 32'hA900_7BFD;
  localparam logic [WORD_WIDTH-1:0] FRAME_PAIR_PRE   = 32'hA980_7BFD;
  // sub sp, sp, #imm
  localparam logic [WORD_WIDTH-1:0] SUB_SP_MASK      = 32'hFF00_03FF;
  localparam logic [WORD_WIDTH-1:0] SUB_SP_MATCH     = 32'hD100_03FF;
  localparam logic [WORD_WIDTH-1:0] INSN_PACIASP     = 32'hD503_233F;
  localparam logic [WORD_WIDTH-1:0] INSN_PACIBSP     = 32'hD503_237F;
  localparam logic [WORD_WIDTH-1:0] INSN_RET         = 32'hD65F_03C0;
  localparam logic [WORD_WIDTH-1:0] INSN_RETAA       = 32'hD65F_0BFF;
  localparam logic [WORD_WIDTH-1:0] INSN_RETAB       = 32'hD65F_0FFF;

  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_FOUND      = 2'd1,
    KIND_NO_BOUNDS  = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_WORD  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_MAX_BACK = 1'b0,
    CFG_MAX_FWD  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic frame_store;
    logic prologue_ext;
    logic plain_ret;
    logic any_ret;
  } word_class_t;

endpackage

`default_nettype wire

>>> sv/afbs_classify.sv
// ----------------------------------------------------------------------------
// afbs_classify
// Decodes one AArch64 instruction word into the classes the scan cares about.
// ----------------------------------------------------------------------------
`default_nettype none

module afbs_classify
  import afbs_pkg::*;
(
  input  wire logic [WORD_WIDTH-1:0] word,
  output word_class_t                cls
);

  logic plain_ret;

  assign plain_ret = (word == INSN_RET);

  assign cls.frame_store  = ((word & FRAME_PAIR_MASK) == FRAME_PAIR_OFF) ||
                            ((word & FRAME_PAIR_MASK) == FRAME_PAIR_PRE);
  assign cls.prologue_ext = ((word & SUB_SP_MASK) == SUB_SP_MATCH) ||
                            (word == INSN_PACIASP) || (word == INSN_PACIBSP);
  assign cls.plain_ret    = plain_ret;
  assign cls.any_ret      = plain_ret || (word == INSN_RETAA) || (word == INSN_RETAB);

endmodule

`default_nettype wire

>>> sv/afbs_core.sv
// ----------------------------------------------------------------------------
// afbs_core
// Scan state machine: limit registers, search state, next-result logic and the
// result register with its output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module afbs_core
  import afbs_pkg::*;
#(
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [STEP_WIDTH-1:0]   cfg_data,
  input  wire logic                    item_valid,
  input  wire logic                    item_op,
  input  wire logic [ADDR_WIDTH-1:0]   item_addr,
  input  wire logic                    item_readable,
  input  wire word_class_t             item_cls,
  output logic                         take,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_kind,
  output logic [ADDR_WIDTH-1:0]        out_read_address,
  output logic [ADDR_WIDTH-1:0]        out_func_start,
  output logic [ADDR_WIDTH-1:0]        out_func_end
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BACK = 2'd1,
    PH_PRO  = 2'd2,
    PH_FWD  = 2'd3
  } phase_t;

  localparam logic [ADDR_WIDTH-1:0] STRIDE   = ADDR_WIDTH'(4);
  localparam logic [ADDR_WIDTH-1:0] SIZE_MAX = ADDR_WIDTH'(MAX_FUNC_SIZE);

  logic [STEP_WIDTH-1:0]   max_back_r;
  logic [STEP_WIDTH-1:0]   max_fwd_r;

  phase_t                  phase_r, phase_nxt;
  logic [ADDR_WIDTH-1:0]   origin_r, origin_nxt;
  logic [STEP_WIDTH-1:0]   step_r, step_nxt;
  logic [PCOUNT_WIDTH-1:0] pcnt_r, pcnt_nxt;
  logic [ADDR_WIDTH-1:0]   found_r, found_nxt;
  logic [ADDR_WIDTH-1:0]   probe_r, probe_nxt;

  logic                    out_valid_r;
  kind_t                   kind_r, kind_nxt;
  logic [ADDR_WIDTH-1:0]   ra_r, ra_nxt;
  logic [ADDR_WIDTH-1:0]   fs_r, fs_nxt;
  logic [ADDR_WIDTH-1:0]   fe_r, fe_nxt;

  logic                    go_fwd;
  logic                    do_finish;
  logic [ADDR_WIDTH-1:0]   finish_end;
  logic [ADDR_WIDTH-1:0]   size;
  logic [ADDR_WIDTH-1:0]   probe_dec;
  logic [ADDR_WIDTH-1:0]   probe_inc;

  assign take      = item_valid && (!out_valid_r || out_ready);
  assign probe_dec = probe_r - STRIDE;
  assign probe_inc = probe_r + STRIDE;
  assign size      = finish_end - found_r;

  always_comb begin
    phase_nxt  = phase_r;
    origin_nxt = origin_r;
    step_nxt   = step_r;
    pcnt_nxt   = pcnt_r;
    found_nxt  = found_r;
    probe_nxt  = probe_r;
    kind_nxt   = KIND_READ;
    ra_nxt     = '0;
    fs_nxt     = '0;
    fe_nxt     = '0;
    go_fwd     = 1'b0;
    do_finish  = 1'b0;
    finish_end = origin_r;

    if (item_op == OP_START) begin
      origin_nxt = item_addr;
      found_nxt  = item_addr;
      pcnt_nxt   = '0;
      if (max_back_r == '0) begin
        go_fwd = 1'b1;
      end else begin
        phase_nxt = PH_BACK;
        step_nxt  = STEP_WIDTH'(1);
        probe_nxt = item_addr - STRIDE;
        ra_nxt    = item_addr - STRIDE;
      end
    end else begin
      unique case (phase_r)
        PH_BACK: begin
          if (!item_readable) begin
            go_fwd = 1'b1;
          end else if (item_cls.frame_store) begin
            found_nxt = probe_r;
            phase_nxt = PH_PRO;
            pcnt_nxt  = PCOUNT_WIDTH'(1);
            probe_nxt = probe_dec;
            ra_nxt    = probe_dec;
          end else if (item_cls.plain_ret) begin
            found_nxt = probe_inc;
            go_fwd    = 1'b1;
          end else if (step_r >= max_back_r) begin
            go_fwd = 1'b1;
          end else begin
            step_nxt  = step_r + STEP_WIDTH'(1);
            probe_nxt = probe_dec;
            ra_nxt    = probe_dec;
          end
        end
        PH_PRO: begin
          if (item_readable && item_cls.prologue_ext) begin
            found_nxt = probe_r;
            if (pcnt_r >= PROLOGUE_LIMIT) begin
              go_fwd = 1'b1;
            end else begin
              pcnt_nxt  = pcnt_r + PCOUNT_WIDTH'(1);
              probe_nxt = probe_dec;
              ra_nxt    = probe_dec;
            end
          end else begin
            go_fwd = 1'b1;
          end
        end
        PH_FWD: begin
          if (!item_readable) begin
            do_finish = 1'b1;
          end else if (item_cls.any_ret) begin
            do_finish  = 1'b1;
            finish_end = probe_inc;
          end else if (step_r >= max_fwd_r) begin
            do_finish = 1'b1;
          end else begin
            step_nxt  = step_r + STEP_WIDTH'(1);
            probe_nxt = probe_inc;
            ra_nxt    = probe_inc;
          end
        end
        PH_IDLE: begin
          kind_nxt = KIND_UNEXPECTED;
        end
      endcase
    end

    if (go_fwd) begin
      phase_nxt = PH_FWD;
      step_nxt  = '0;
      pcnt_nxt  = '0;
      probe_nxt = origin_nxt;
      ra_nxt    = origin_nxt;
    end

    if (do_finish) begin
      phase_nxt = PH_IDLE;
      if (size < STRIDE || size > SIZE_MAX) begin
        kind_nxt = KIND_NO_BOUNDS;
      end else begin
        kind_nxt = KIND_FOUND;
        fs_nxt   = found_r;
        fe_nxt   = finish_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_back_r  <= STEP_WIDTH'(1024);
      max_fwd_r   <= STEP_WIDTH'(4096);
      phase_r     <= PH_IDLE;
      origin_r    <= '0;
      step_r      <= '0;
      pcnt_r      <= '0;
      found_r     <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_BACK: max_back_r <= cfg_data;
          CFG_MAX_FWD:  max_fwd_r  <= cfg_data;
        endcase
      end
      if (take) begin
        phase_r     <= phase_nxt;
        origin_r    <= origin_nxt;
        step_r      <= step_nxt;
        pcnt_r      <= pcnt_nxt;
        found_r     <= found_nxt;
        probe_r     <= probe_nxt;
        out_valid_r <= 1'b1;
        kind_r      <= kind_nxt;
        ra_r        <= ra_nxt;
        fs_r        <= fs_nxt;
        fe_r        <= fe_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_read_address = ra_r;
  assign out_func_start   = fs_r;
  assign out_func_end     = fe_r;

`ifndef SYNTHESIS
  a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_FOUND) |->
      ((fe_r - fs_r) >= STRIDE && (fe_r - fs_r) <= SIZE_MAX))
    else $error("bounds result with out-of-range size");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != KIND_FOUND) |-> (fs_r == '0 && fe_r == '0))
    else $error("bounds fields set on a non-bounds result");

  a_pcnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PROLOGUE_LIMIT)
    else $error("prologue count past limit");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item_op == OP_START) |=> (phase_r != PH_IDLE && kind_r == KIND_READ))
    else $error("start did not launch a search");

  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item_op == OP_WORD && phase_r == PH_IDLE) |=>
      (kind_r == KIND_UNEXPECTED && phase_r == PH_IDLE))
    else $error("word while idle not flagged");
`endif

endmodule

`default_nettype wire

>>> sv/arm64_function_bound_scan_unit.sv
// ----------------------------------------------------------------------------
// arm64_function_bound_scan_unit
// Finds the bounds of the AArch64 function around a code address by driving
// word reads and classifying each returned instruction word.
// ----------------------------------------------------------------------------
// Each transfer on the input channel (a start address or a returned word)
// produces exactly one result transfer: the next read address, the final
// verdict, or an unexpected kind for a word that arrives while idle. Items
// pass an input register and then a result register before their result is
// valid. One item per cycle is sustained as long as the result side keeps
// taking; the loop through the scan state registers (phase, step counter,
// probe address) sets that rate.
// Reads go backward from the start address for a frame-pair store or an
// earlier ret, extend over up to four prologue words, then go forward from the
// start address for ret, retaa or retab. The user must write limits on the
// cfg port only while no search is in flight; the block does not enforce it.
`default_nettype none

module arm64_function_bound_scan_unit
  import afbs_pkg::*;
#(
  parameter int ADDR_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [STEP_WIDTH-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [ADDR_WIDTH-1:0] in_start_address,
  input  wire logic [WORD_WIDTH-1:0] in_word,
  input  wire logic                  in_readable,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_kind,
  output logic [ADDR_WIDTH-1:0]      out_read_address,
  output logic [ADDR_WIDTH-1:0]      out_func_start,
  output logic [ADDR_WIDTH-1:0]      out_func_end
);

  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [ADDR_WIDTH-1:0] s1_addr_r;
  logic [WORD_WIDTH-1:0] s1_word_r;
  logic                  s1_readable_r;
  word_class_t           s1_cls;
  logic                  core_take;

  assign in_ready = !s1_valid_r || core_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r    <= 1'b1;
        s1_op_r       <= in_op;
        s1_addr_r     <= in_start_address;
        s1_word_r     <= in_word;
        s1_readable_r <= in_readable;
      end else if (core_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  afbs_classify u_classify (
    .word (s1_word_r),
    .cls  (s1_cls)
  );

  afbs_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (s1_valid_r),
    .item_op          (s1_op_r),
    .item_addr        (s1_addr_r),
    .item_readable    (s1_readable_r),
    .item_cls         (s1_cls),
    .take             (core_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_read_address (out_read_address),
    .out_func_start   (out_func_start),
    .out_func_end     (out_func_end)
  );

endmodule

`default_nettype wire
